/* rtl/ocpt_pkg.sv */
// ----------------------------------------------------------------------------
// ocpt_pkg
// Shared widths, codes, node summary types and the reset-size helper for the
// ordered pair count tree.
// ----------------------------------------------------------------------------
package ocpt_pkg;

  // tree shape (leaf count is a power of two)
  localparam int LEAVES  = 1024;
  localparam int LEVELS  = $clog2(LEAVES);
  localparam int ADDR_W  = LEVELS + 1;      // heap index of a node, 1..2*LEAVES-1
  localparam int CUR_W   = ADDR_W + 1;      // walk cursor, may step one past the last node
  localparam int DEPTH   = 2 * LEAVES;

  // field widths
  localparam int POS_W   = 11;
  localparam int BEGIN_W = LEVELS + 1;      // begins or size of one node
  localparam int PAIR_W  = 19;

  // operation codes
  localparam logic OP_TOGGLE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // stored per node
  typedef struct packed {
    logic [BEGIN_W-1:0] begins;
    logic [PAIR_W-1:0]  pairs;
  } node_t;

  // summary of a run of points, as merged left to right
  typedef struct packed {
    logic [BEGIN_W-1:0] begins;
    logic [BEGIN_W-1:0] size;
    logic [PAIR_W-1:0]  pairs;
  } summary_t;

  // number of points under a node: LEAVES shifted down by the node's depth
  function automatic logic [BEGIN_W-1:0] node_size(input logic [ADDR_W-1:0] idx);
    logic [BEGIN_W-1:0] size;
    size = '0;
    for (int b = 0; b < ADDR_W; b++) begin
      if (idx[b]) size = BEGIN_W'(LEAVES >> b);
    end
    return size;
  endfunction

endpackage

/* rtl/ocpt_in_if.sv */
// ----------------------------------------------------------------------------
// ocpt_in_if
// Input channel: one toggle or query item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ocpt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [ocpt_pkg::POS_W-1:0] first;
  logic [ocpt_pkg::POS_W-1:0] last;

  modport source (output valid, output op, output first, output last, input ready);
  modport sink   (input valid, input op, input first, input last, output ready);
endinterface

/* rtl/ocpt_out_if.sv */
// ----------------------------------------------------------------------------
// ocpt_out_if
// Result channel: one pair count item per query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ocpt_out_if;
  logic                        valid;
  logic                        ready;
  logic [ocpt_pkg::PAIR_W-1:0] pair_count;
  logic                        bad_position;

  modport source (output valid, output pair_count, output bad_position, input ready);
  modport sink   (input valid, input pair_count, input bad_position, output ready);
endinterface

/* rtl/ocpt_ram.sv */
// ----------------------------------------------------------------------------
// ocpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ocpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ocpt_merge.sv */
// ----------------------------------------------------------------------------
// ocpt_merge
// Shared merge unit: joins a left summary and a right summary. Pairs across
// the boundary are the left begins times the right ends.
// ----------------------------------------------------------------------------
module ocpt_merge (
  input  ocpt_pkg::summary_t lhs,
  input  ocpt_pkg::summary_t rhs,
  output ocpt_pkg::summary_t sum
);

  logic [ocpt_pkg::BEGIN_W-1:0]   rhs_ends;
  logic [2*ocpt_pkg::BEGIN_W-1:0] cross_pairs;

  // ends on the right, then cross pairs
  assign rhs_ends    = rhs.size - rhs.begins;
  assign cross_pairs = lhs.begins * rhs_ends;

  // combined summary
  assign sum.begins = lhs.begins + rhs.begins;
  assign sum.size   = lhs.size + rhs.size;
  assign sum.pairs  = lhs.pairs + rhs.pairs + cross_pairs[ocpt_pkg::PAIR_W-1:0];

endmodule

/* rtl/ordered_pair_count_tree_top.sv */
// ----------------------------------------------------------------------------
// ordered_pair_count_tree_top
// Segment tree over begin/end points. Toggles flip a leaf and rebuild its path
// to the root; queries count begin-before-end pairs over a range.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------
//   in_if    | in  | valid/ready  | op, first, last
//   out_if   | out | valid/ready  | pair_count, bad_position
//
// After reset a clearing pass writes every tree node with in_if.ready low.
// A toggle does a leaf read, then one node read, merge and write per level
// through the single RAM port pair. A query walks both range edges upwards,
// at most two node reads per level; a bad or empty range skips the walk.
// Results sit in an output register, so a stalled out_if holds only the
// final step of the next query.
// ----------------------------------------------------------------------------
module ordered_pair_count_tree_top (
  input  logic        clk,
  input  logic        rst_n,
  ocpt_in_if.sink     in_if,
  ocpt_out_if.source  out_if
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_TLEAF = 6'b000100,
    S_TUP   = 6'b001000,
    S_WALK  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [ocpt_pkg::ADDR_W-1:0]  init_r, init_nxt;
  logic [ocpt_pkg::ADDR_W-1:0]  node_r, node_nxt;
  ocpt_pkg::summary_t           cur_r, cur_nxt;
  logic [ocpt_pkg::CUR_W-1:0]   l_r, l_nxt;
  logic [ocpt_pkg::CUR_W-1:0]   r_r, r_nxt;
  logic                         sub_r, sub_nxt;
  logic [ocpt_pkg::BEGIN_W-1:0] size_r, size_nxt;
  ocpt_pkg::summary_t           accl_r, accl_nxt;
  ocpt_pkg::summary_t           accr_r, accr_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic                         rd_left_r, rd_left_nxt;
  logic [ocpt_pkg::BEGIN_W-1:0] rd_size_r, rd_size_nxt;
  logic                         bad_r, bad_nxt;
  logic                         out_vld_r, out_vld_nxt;
  logic [ocpt_pkg::PAIR_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                         out_bad_r, out_bad_nxt;

  // ram ports
  logic                         ram_we;
  logic [ocpt_pkg::ADDR_W-1:0]  ram_waddr;
  ocpt_pkg::node_t              ram_wdata;
  logic [ocpt_pkg::ADDR_W-1:0]  ram_raddr;
  logic [$bits(ocpt_pkg::node_t)-1:0] ram_rdata;
  ocpt_pkg::node_t              rd_node;

  // merge unit ports
  ocpt_pkg::summary_t           mrg_lhs, mrg_rhs, mrg_sum;
  ocpt_pkg::summary_t           mem_sum;

  // decode of the incoming item
  logic [ocpt_pkg::CUR_W-1:0]   first_leaf, last_leaf;
  logic                         first_bad, last_bad;
  logic [ocpt_pkg::ADDR_W-1:0]  parent;
  logic [ocpt_pkg::CUR_W-1:0]   r_tmp;
  logic [ocpt_pkg::BEGIN_W-1:0] leaf_begins;

  assign first_leaf = ocpt_pkg::CUR_W'(in_if.first) + ocpt_pkg::CUR_W'(ocpt_pkg::LEAVES - 1);
  assign last_leaf  = ocpt_pkg::CUR_W'(in_if.last) + ocpt_pkg::CUR_W'(ocpt_pkg::LEAVES - 1);
  assign first_bad  = (in_if.first == '0) ||
                      (in_if.first > ocpt_pkg::POS_W'(ocpt_pkg::LEAVES));
  assign last_bad   = (in_if.last == '0) ||
                      (in_if.last > ocpt_pkg::POS_W'(ocpt_pkg::LEAVES));
  assign parent     = node_r >> 1;
  assign rd_node    = ram_rdata;
  assign leaf_begins = {rd_node.begins[ocpt_pkg::BEGIN_W-1:1], ~rd_node.begins[0]};

  // node store: begin count and pair count per tree node
  ocpt_ram #(
    .WIDTH ($bits(ocpt_pkg::node_t)),
    .DEPTH (ocpt_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // node read back as a summary, size from the level it was read at
  always_comb begin
    mem_sum.begins = rd_node.begins;
    mem_sum.pairs  = rd_node.pairs;
    mem_sum.size   = (state_r == S_WALK) ? rd_size_r : size_r;
  end

  // operand selection for the shared merge unit
  always_comb begin
    mrg_lhs = accl_r;
    mrg_rhs = accr_r;
    case (state_r)
      S_TUP: begin
        if (node_r[0]) begin
          mrg_lhs = mem_sum;
          mrg_rhs = cur_r;
        end else begin
          mrg_lhs = cur_r;
          mrg_rhs = mem_sum;
        end
      end
      S_WALK: begin
        if (rd_left_r) begin
          mrg_lhs = accl_r;
          mrg_rhs = mem_sum;
        end else begin
          mrg_lhs = mem_sum;
          mrg_rhs = accr_r;
        end
      end
      default: begin
        mrg_lhs = accl_r;
        mrg_rhs = accr_r;
      end
    endcase
  end

  ocpt_merge u_merge (
    .lhs (mrg_lhs),
    .rhs (mrg_rhs),
    .sum (mrg_sum)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    init_nxt    = init_r;
    node_nxt    = node_r;
    cur_nxt     = cur_r;
    l_nxt       = l_r;
    r_nxt       = r_r;
    sub_nxt     = sub_r;
    size_nxt    = size_r;
    accl_nxt    = accl_r;
    accr_nxt    = accr_r;
    rd_vld_nxt  = 1'b0;
    rd_left_nxt = rd_left_r;
    rd_size_nxt = rd_size_r;
    bad_nxt     = bad_r;
    out_vld_nxt = out_vld_r && !out_if.ready;
    out_cnt_nxt = out_cnt_r;
    out_bad_nxt = out_bad_r;
    ram_we      = 1'b0;
    ram_waddr   = node_r;
    ram_wdata   = '0;
    ram_raddr   = node_r ^ ocpt_pkg::ADDR_W'(1);
    r_tmp       = r_r;

    case (state_r)
      // clearing pass: every node gets its size as begin count
      S_INIT: begin
        ram_we           = 1'b1;
        ram_waddr        = init_r;
        ram_wdata.begins = ocpt_pkg::node_size(init_r);
        ram_wdata.pairs  = '0;
        init_nxt         = init_r + ocpt_pkg::ADDR_W'(1);
        if (&init_r) state_nxt = S_IDLE;
      end

      // accept an item
      S_IDLE: begin
        if (in_if.valid) begin
          if (in_if.op == ocpt_pkg::OP_TOGGLE) begin
            if (!first_bad) begin
              ram_raddr = first_leaf[ocpt_pkg::ADDR_W-1:0];
              node_nxt  = first_leaf[ocpt_pkg::ADDR_W-1:0];
              size_nxt  = ocpt_pkg::BEGIN_W'(1);
              state_nxt = S_TLEAF;
            end
          end else begin
            accl_nxt = '0;
            accr_nxt = '0;
            bad_nxt  = first_bad || last_bad;
            l_nxt    = first_leaf;
            r_nxt    = last_leaf;
            sub_nxt  = 1'b0;
            size_nxt = ocpt_pkg::BEGIN_W'(1);
            if (first_bad || last_bad || (in_if.first > in_if.last)) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_WALK;
            end
          end
        end
      end

      // leaf flipped and written, sibling read issued
      S_TLEAF: begin
        cur_nxt.begins   = leaf_begins;
        cur_nxt.size     = ocpt_pkg::BEGIN_W'(1);
        cur_nxt.pairs    = '0;
        ram_we           = 1'b1;
        ram_waddr        = node_r;
        ram_wdata.begins = leaf_begins;
        ram_wdata.pairs  = '0;
        ram_raddr        = node_r ^ ocpt_pkg::ADDR_W'(1);
        state_nxt        = S_TUP;
      end

      // one level up per cycle: merge with sibling, write parent
      S_TUP: begin
        ram_we           = 1'b1;
        ram_waddr        = parent;
        ram_wdata.begins = mrg_sum.begins;
        ram_wdata.pairs  = mrg_sum.pairs;
        cur_nxt          = mrg_sum;
        node_nxt         = parent;
        size_nxt         = size_r << 1;
        ram_raddr        = parent ^ ocpt_pkg::ADDR_W'(1);
        if (parent == ocpt_pkg::ADDR_W'(1)) state_nxt = S_IDLE;
      end

      // range walk: left edge appends, right edge prepends
      S_WALK: begin
        if (rd_vld_r) begin
          if (rd_left_r) accl_nxt = mrg_sum;
          else           accr_nxt = mrg_sum;
        end
        if (!sub_r && (l_r > r_r)) begin
          if (!rd_vld_r) state_nxt = S_FIN;
        end else if (!sub_r && l_r[0]) begin
          ram_raddr   = l_r[ocpt_pkg::ADDR_W-1:0];
          rd_vld_nxt  = 1'b1;
          rd_left_nxt = 1'b1;
          rd_size_nxt = size_r;
          l_nxt       = l_r + ocpt_pkg::CUR_W'(1);
          sub_nxt     = 1'b1;
        end else begin
          if (!r_r[0]) begin
            ram_raddr   = r_r[ocpt_pkg::ADDR_W-1:0];
            rd_vld_nxt  = 1'b1;
            rd_left_nxt = 1'b0;
            rd_size_nxt = size_r;
            r_tmp       = r_r - ocpt_pkg::CUR_W'(1);
          end
          l_nxt    = l_r >> 1;
          r_nxt    = r_tmp >> 1;
          size_nxt = size_r << 1;
          sub_nxt  = 1'b0;
        end
      end

      // join both edges and hand over the result
      S_FIN: begin
        if (!out_vld_r || out_if.ready) begin
          out_vld_nxt = 1'b1;
          out_cnt_nxt = bad_r ? '0 : mrg_sum.pairs;
          out_bad_nxt = bad_r;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      init_r    <= '0;
      rd_vld_r  <= 1'b0;
      sub_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      init_r    <= init_nxt;
      rd_vld_r  <= rd_vld_nxt;
      sub_r     <= sub_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    cur_r     <= cur_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    size_r    <= size_nxt;
    accl_r    <= accl_nxt;
    accr_r    <= accr_nxt;
    rd_left_r <= rd_left_nxt;
    rd_size_r <= rd_size_nxt;
    bad_r     <= bad_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_bad_r <= out_bad_nxt;
  end

  // channel outputs
  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_vld_r;
  assign out_if.pair_count   = out_cnt_r;
  assign out_if.bad_position = out_bad_r;

  // a node read in flight belongs to the range walk
  a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_WALK))
    else $error("node read outstanding outside range walk");

  // the path rebuild never starts from the root
  a_tup_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TUP) |-> (node_r > ocpt_pkg::ADDR_W'(1)))
    else $error("path rebuild at root node");

  // a bad position always reports a zero count
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.bad_position) |-> (out_if.pair_count == '0))
    else $error("bad position item with non-zero count");

  // a finished query lands in the output register on the next edge
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && !out_vld_r) |=> (out_vld_r && (state_r == S_IDLE)))
    else $error("finished query not delivered");

endmodule

/* sim/tb_ordered_pair_count_tree_top.sv */
// ----------------------------------------------------------------------------
// tb_ordered_pair_count_tree_top
// Self-checking bench for the ordered pair count tree. A driver feeds toggle
// and query items from a pending queue. A bit-level shadow of the begin/end
// row predicts every query result, and a monitor checks each result against
// the oldest prediction. Both channels idle at random in the first two of
// three phases, and the driver waits between phases for all results.
// ----------------------------------------------------------------------------
module tb_ordered_pair_count_tree_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                       op;
    logic [ocpt_pkg::POS_W-1:0] first;
    logic [ocpt_pkg::POS_W-1:0] last;
  } tree_op_t;

  typedef struct packed {
    logic [ocpt_pkg::PAIR_W-1:0] pair_count;
    logic                        bad_position;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ocpt_in_if  in_if ();
  ocpt_out_if out_if ();

  ordered_pair_count_tree_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // clock
  always #2 clk = ~clk;

  // shadow of the point row: 1 marks a begin, 0 an end
  logic         begin_mark [1:ocpt_pkg::LEAVES];
  tree_op_t     pending_ops [$];
  pair_result_t expected_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int mismatch_count;
  int toggles_sent;
  int queries_sent;
  int bad_queries;
  int empty_queries;
  int results_checked;
  int largest_count;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // pairs i<j in lo..hi with a begin at i and an end at j
  function automatic pair_result_t predict_pairs(logic [ocpt_pkg::POS_W-1:0] lo,
                                                 logic [ocpt_pkg::POS_W-1:0] hi);
    pair_result_t res;
    int           begins_seen;
    longint       pairs;
    res         = '0;
    begins_seen = 0;
    pairs       = 0;
    if (lo == 0 || lo > ocpt_pkg::LEAVES || hi == 0 || hi > ocpt_pkg::LEAVES) begin
      res.bad_position = 1'b1;
    end else if (lo <= hi) begin
      for (int p = lo; p <= hi; p++) begin
        if (begin_mark[p]) begins_seen++;
        else pairs += begins_seen;
      end
      res.pair_count = ocpt_pkg::PAIR_W'(pairs);
    end
    return res;
  endfunction

  // update the shadow row or record the expected result of an accepted item
  task automatic apply_item(tree_op_t item);
    if (item.op == ocpt_pkg::OP_TOGGLE) begin
      toggles_sent++;
      if (item.first >= 1 && item.first <= ocpt_pkg::LEAVES)
        begin_mark[item.first] = ~begin_mark[item.first];
    end else begin
      queries_sent++;
      if (item.first == 0 || item.first > ocpt_pkg::LEAVES ||
          item.last == 0 || item.last > ocpt_pkg::LEAVES)
        bad_queries++;
      else if (item.first > item.last)
        empty_queries++;
      expected_results.push_back(predict_pairs(item.first, item.last));
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_op(logic op, int first, int last);
    tree_op_t item;
    item.op    = op;
    item.first = ocpt_pkg::POS_W'(first);
    item.last  = ocpt_pkg::POS_W'(last);
    pending_ops.push_back(item);
  endtask

  // mostly in-range toggles and queries, some local bursts, a little noise
  task automatic queue_random_ops(int count);
    int made;
    int pick;
    int lo;
    int hi;
    int span;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 42) begin
        push_op(ocpt_pkg::OP_TOGGLE, $urandom_range(1, ocpt_pkg::LEAVES),
                $urandom_range(0, 2047));
        made++;
      end else if (pick < 47) begin
        // noise, mostly out-of-range positions
        push_op(1'($urandom_range(1)), $urandom_range(0, 2047), $urandom_range(0, 2047));
        made++;
      end else if (pick < 60) begin
        push_op(ocpt_pkg::OP_QUERY, $urandom_range(1, 64),
                $urandom_range(ocpt_pkg::LEAVES - 64, ocpt_pkg::LEAVES));
        made++;
      end else if (pick < 78) begin
        lo = $urandom_range(1, ocpt_pkg::LEAVES);
        hi = $urandom_range(1, ocpt_pkg::LEAVES);
        if (lo > hi) push_op(ocpt_pkg::OP_QUERY, hi, lo);
        else push_op(ocpt_pkg::OP_QUERY, lo, hi);
        made++;
      end else if (pick < 82) begin
        // empty range
        lo = $urandom_range(2, ocpt_pkg::LEAVES);
        push_op(ocpt_pkg::OP_QUERY, lo, $urandom_range(1, lo - 1));
        made++;
      end else if (pick < 92) begin
        // burst of toggles in a small window, then a query over it
        lo   = $urandom_range(1, ocpt_pkg::LEAVES - 15);
        span = $urandom_range(4, 12);
        for (int k = 0; k < span; k++)
          push_op(ocpt_pkg::OP_TOGGLE, lo + $urandom_range(0, 15), $urandom_range(0, 2047));
        push_op(ocpt_pkg::OP_QUERY, lo,
                ($urandom_range(1)) ? lo + 15 : $urandom_range(lo, ocpt_pkg::LEAVES));
        made += span + 1;
      end else begin
        lo = $urandom_range(1, ocpt_pkg::LEAVES);
        hi = lo + $urandom_range(0, 8);
        push_op(ocpt_pkg::OP_QUERY, lo, (hi > ocpt_pkg::LEAVES) ? ocpt_pkg::LEAVES : hi);
        made++;
      end
    end
  endtask

  // edges of the row, every error and empty case, ignored toggles
  task automatic queue_directed_ops();
    push_op(ocpt_pkg::OP_QUERY, 1, ocpt_pkg::LEAVES);
    push_op(ocpt_pkg::OP_TOGGLE, ocpt_pkg::LEAVES, 0);
    push_op(ocpt_pkg::OP_QUERY, 1, ocpt_pkg::LEAVES);
    push_op(ocpt_pkg::OP_QUERY, ocpt_pkg::LEAVES, ocpt_pkg::LEAVES);
    push_op(ocpt_pkg::OP_QUERY, 1, 1);
    push_op(ocpt_pkg::OP_TOGGLE, 1, 2047);
    push_op(ocpt_pkg::OP_QUERY, 1, 2);
    push_op(ocpt_pkg::OP_QUERY, 1, ocpt_pkg::LEAVES);
    push_op(ocpt_pkg::OP_QUERY, 5, 4);
    push_op(ocpt_pkg::OP_QUERY, ocpt_pkg::LEAVES, 1);
    push_op(ocpt_pkg::OP_QUERY, 0, 5);
    push_op(ocpt_pkg::OP_QUERY, 5, 0);
    push_op(ocpt_pkg::OP_QUERY, 0, 0);
    push_op(ocpt_pkg::OP_QUERY, ocpt_pkg::LEAVES + 1, ocpt_pkg::LEAVES + 1);
    push_op(ocpt_pkg::OP_QUERY, 2047, 2047);
    push_op(ocpt_pkg::OP_QUERY, 1, ocpt_pkg::LEAVES + 1);
    push_op(ocpt_pkg::OP_QUERY, 1500, 3);
    push_op(ocpt_pkg::OP_TOGGLE, 0, 0);
    push_op(ocpt_pkg::OP_TOGGLE, 2047, 1024);
    push_op(ocpt_pkg::OP_TOGGLE, ocpt_pkg::LEAVES + 1, 5);
    push_op(ocpt_pkg::OP_QUERY, 1, ocpt_pkg::LEAVES);
    push_op(ocpt_pkg::OP_TOGGLE, 512, 1023);
    push_op(ocpt_pkg::OP_TOGGLE, 513, 1);
    push_op(ocpt_pkg::OP_QUERY, 500, 600);
    push_op(ocpt_pkg::OP_QUERY, 2, ocpt_pkg::LEAVES - 1);
  endtask

  // wait for the driver to empty its queue, then for every result
  task automatic drain_phase();
    while (pending_ops.size() != 0 || in_if.valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------
  tree_op_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) apply_item('{in_if.op, in_if.first, in_if.last});
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item   = pending_ops.pop_front();
        in_if.valid <= 1'b1;
        in_if.op    <= next_item.op;
        in_if.first <= next_item.first;
        in_if.last  <= next_item.last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor
  // ---------------------------------------------------------------------------
  pair_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: count %0d bad %0b",
                                    out_if.pair_count, out_if.bad_position));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_if.pair_count > largest_count) largest_count = int'(out_if.pair_count);
          if (out_if.pair_count !== want.pair_count)
            report_mismatch($sformatf("pair_count %0d, expected %0d",
                                      out_if.pair_count, want.pair_count));
          if (out_if.bad_position !== want.bad_position)
            report_mismatch($sformatf("bad_position %0b, expected %0b",
                                      out_if.bad_position, want.bad_position));
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid     = 1'b0;
    in_if.op        = ocpt_pkg::OP_TOGGLE;
    in_if.first     = '0;
    in_if.last      = '0;
    out_if.ready    = 1'b0;
    rst_n           = 1'b0;
    cycle_count     = 0;
    mismatch_count  = 0;
    toggles_sent    = 0;
    queries_sent    = 0;
    bad_queries     = 0;
    empty_queries   = 0;
    results_checked = 0;
    largest_count   = 0;
    send_idle_pct   = 19;
    recv_idle_pct   = 58;
    for (int p = 1; p <= ocpt_pkg::LEAVES; p++) begin_mark[p] = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    @(negedge clk);
    queue_directed_ops();
    queue_random_ops(400);
    drain_phase();

    // roles swapped
    send_idle_pct = 58;
    recv_idle_pct = 19;
    queue_random_ops(425);
    drain_phase();

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_ops(425);
    drain_phase();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("ran %0d toggles and %0d queries (%0d with bad positions, %0d empty ranges)",
             toggles_sent, queries_sent, bad_queries, empty_queries);
    $display("checked %0d results, largest pair count %0d, %0d mismatches",
             results_checked, largest_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
